// File: design/hlc_pkg.sv
// Types, constants and a helper function shared by the line clipper modules.
package hlc_pkg;

	localparam int NPLANES = 6;
	localparam int TFRAC   = 30;
	localparam int TBITS   = TFRAC + 1;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);
	localparam logic [TBITS-1:0] TONE = TBITS'(1) << TFRAC;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] a_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] b_w;
	} seg_t;

	typedef struct packed {
		logic               visible;
		logic signed [31:0] out_a_x;
		logic signed [31:0] out_a_y;
		logic signed [31:0] out_a_z;
		logic signed [31:0] out_a_w;
		logic signed [31:0] out_b_x;
		logic signed [31:0] out_b_y;
		logic signed [31:0] out_b_z;
		logic signed [31:0] out_b_w;
	} clip_t;

	typedef struct packed {
		seg_t                         seg;
		logic                         code_a_nz;
		logic                         code_b_nz;
		logic                         rej;
		logic [NPLANES-1:0]           exit_m;
		logic [NPLANES-1:0]           entry_m;
		logic [NPLANES-1:0][33:0]     num;
		logic [NPLANES-1:0][34:0]     den;
	} ent_t;

	function automatic logic [31:0] sat32(input logic signed [36:0] v);
		logic [31:0] r;
		if (v > 37'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -37'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: design/hlc_front.sv
// Front end: boundary values, outcodes and crossing operands for one segment.
module hlc_front (
	input  hlc_pkg::seg_t seg,
	output hlc_pkg::ent_t ent
);

	logic signed [33:0] ca [hlc_pkg::NPLANES];
	logic signed [33:0] cb [hlc_pkg::NPLANES];
	logic [hlc_pkg::NPLANES-1:0] code_a;
	logic [hlc_pkg::NPLANES-1:0] code_b;
	logic [33:0] mag_a [hlc_pkg::NPLANES];
	logic [33:0] mag_b [hlc_pkg::NPLANES];

	always_comb begin
		ca[0] = 34'(seg.a_w) + 34'(seg.a_x);
		ca[1] = 34'(seg.a_w) - 34'(seg.a_x);
		ca[2] = 34'(seg.a_w) + 34'(seg.a_y);
		ca[3] = 34'(seg.a_w) - 34'(seg.a_y);
		ca[4] = 34'(seg.a_w) + 34'(seg.a_z);
		ca[5] = 34'(seg.a_w) - 34'(seg.a_z);
		cb[0] = 34'(seg.b_w) + 34'(seg.b_x);
		cb[1] = 34'(seg.b_w) - 34'(seg.b_x);
		cb[2] = 34'(seg.b_w) + 34'(seg.b_y);
		cb[3] = 34'(seg.b_w) - 34'(seg.b_y);
		cb[4] = 34'(seg.b_w) + 34'(seg.b_z);
		cb[5] = 34'(seg.b_w) - 34'(seg.b_z);
		for (int i = 0; i < hlc_pkg::NPLANES; i++) begin
			code_a[i] = (ca[i] <= 34'sd0);
			code_b[i] = (cb[i] <= 34'sd0);
			mag_a[i] = ca[i][33] ? 34'(-ca[i]) : 34'(ca[i]);
			mag_b[i] = cb[i][33] ? 34'(-cb[i]) : 34'(cb[i]);
			ent.num[i] = mag_a[i];
			ent.den[i] = 35'(mag_a[i]) + 35'(mag_b[i]);
			ent.exit_m[i] = cb[i][33];
			ent.entry_m[i] = !cb[i][33] && ca[i][33];
		end
		ent.seg = seg;
		ent.code_a_nz = |code_a;
		ent.code_b_nz = |code_b;
		ent.rej = |(code_a & code_b);
	end

endmodule

// File: design/hlc_fifo.sv
// Short queue between the front end and the back end.
module hlc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hlc_pkg::ent_t push_word,
	output logic          full,
	output logic          rd_valid_q,
	output hlc_pkg::ent_t rd_word_q
);

	hlc_pkg::ent_t mem [hlc_pkg::QDEPTH];
	logic [hlc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [hlc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [hlc_pkg::QCNT_W-1:0] cnt_q;
	logic pop;

	assign full = (cnt_q == hlc_pkg::QCNT_W'(hlc_pkg::QDEPTH));
	assign pop  = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_word;
		end
		if (pop) begin
			rd_word_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			cnt_q      <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= pop;
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + hlc_pkg::QCNT_W'(push) - hlc_pkg::QCNT_W'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= hlc_pkg::QCNT_W'(hlc_pkg::QDEPTH)) else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rd_valid_q) else $error("popped word not presented");
`endif

endmodule

// File: design/hlc_div.sv
// Pipelined restoring divider, six lanes, one quotient bit per stage.
module hlc_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  hlc_pkg::ent_t in_ent,
	output logic          out_valid,
	output hlc_pkg::ent_t out_ent,
	output logic [hlc_pkg::NPLANES-1:0][hlc_pkg::TBITS-1:0] out_quo
);

	localparam int STG = hlc_pkg::TBITS;

	logic [STG-1:0] vld_q;
	hlc_pkg::ent_t ent_q [STG];
	logic [hlc_pkg::NPLANES-1:0][35:0] rem_q [STG];
	logic [hlc_pkg::NPLANES-1:0][hlc_pkg::TBITS-1:0] quo_q [STG];

	for (genvar s = 0; s < STG; s++) begin : g_stg
		hlc_pkg::ent_t src_ent;
		logic src_v;
		logic [hlc_pkg::NPLANES-1:0][35:0] src_rem;
		logic [hlc_pkg::NPLANES-1:0][hlc_pkg::TBITS-1:0] src_quo;

		if (s == 0) begin : g_first
			always_comb begin
				src_ent = in_ent;
				src_v = in_valid;
				src_quo = '0;
				for (int l = 0; l < hlc_pkg::NPLANES; l++) begin
					src_rem[l] = {2'b00, in_ent.num[l]};
				end
			end
		end else begin : g_next
			always_comb begin
				src_ent = ent_q[s-1];
				src_v = vld_q[s-1];
				src_quo = quo_q[s-1];
				for (int l = 0; l < hlc_pkg::NPLANES; l++) begin
					src_rem[l] = {rem_q[s-1][l][34:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[s] <= 1'b0;
			end else begin
				vld_q[s] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			ent_q[s] <= src_ent;
			for (int l = 0; l < hlc_pkg::NPLANES; l++) begin
				if (src_rem[l] >= {1'b0, src_ent.den[l]}) begin
					rem_q[s][l] <= src_rem[l] - {1'b0, src_ent.den[l]};
					quo_q[s][l] <= {src_quo[l][hlc_pkg::TBITS-2:0], 1'b1};
				end else begin
					rem_q[s][l] <= src_rem[l];
					quo_q[s][l] <= {src_quo[l][hlc_pkg::TBITS-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_q[STG-1];
	assign out_ent   = ent_q[STG-1];
	assign out_quo   = quo_q[STG-1];

endmodule

// File: design/hlc_back.sv
// Back end: crossing division, parameter interval and endpoint interpolation.
module hlc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  hlc_pkg::ent_t  in_ent,
	output logic           done,
	output hlc_pkg::clip_t result
);

	logic          dv;
	hlc_pkg::ent_t de;
	logic [hlc_pkg::NPLANES-1:0][hlc_pkg::TBITS-1:0] dq;

	hlc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ent    (in_ent),
		.out_valid (dv),
		.out_ent   (de),
		.out_quo   (dq)
	);

	logic [hlc_pkg::TBITS-1:0] tin;
	logic [hlc_pkg::TBITS-1:0] tout;

	always_comb begin
		tin = '0;
		tout = hlc_pkg::TONE;
		for (int l = 0; l < hlc_pkg::NPLANES; l++) begin
			if (de.exit_m[l]) begin
				if (dq[l] < tout) begin
					tout = dq[l];
				end
			end else if (de.entry_m[l]) begin
				if (dq[l] > tin) begin
					tin = dq[l];
				end
			end
		end
	end

	logic vld_s1, vis_s1, mov_a_s1, mov_b_s1;
	hlc_pkg::seg_t seg_s1;
	logic [hlc_pkg::TBITS-1:0] tin_s1, tout_s1;

	always_ff @(posedge clk) begin
		seg_s1   <= de.seg;
		tin_s1   <= tin;
		tout_s1  <= tout;
		vis_s1   <= !de.rej && !((de.code_a_nz || de.code_b_nz) && (tin > tout));
		mov_a_s1 <= !de.rej && de.code_a_nz && !(tin > tout);
		mov_b_s1 <= !de.rej && de.code_b_nz && !(tin > tout);
	end

	logic signed [31:0] pa [4];
	logic signed [31:0] pb [4];

	always_comb begin
		pa[0] = seg_s1.a_x; pa[1] = seg_s1.a_y; pa[2] = seg_s1.a_z; pa[3] = seg_s1.a_w;
		pb[0] = seg_s1.b_x; pb[1] = seg_s1.b_y; pb[2] = seg_s1.b_z; pb[3] = seg_s1.b_w;
	end

	logic vld_s2, vis_s2, mov_a_s2, mov_b_s2;
	hlc_pkg::seg_t seg_s2;
	logic signed [49:0] alo_s2 [4];
	logic signed [48:0] ahi_s2 [4];
	logic signed [49:0] blo_s2 [4];
	logic signed [48:0] bhi_s2 [4];
	logic signed [32:0] diff [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			diff[i] = 33'(pb[i]) - 33'(pa[i]);
		end
	end

	always_ff @(posedge clk) begin
		seg_s2   <= seg_s1;
		vis_s2   <= vis_s1;
		mov_a_s2 <= mov_a_s1;
		mov_b_s2 <= mov_b_s1;
		for (int i = 0; i < 4; i++) begin
			alo_s2[i] <= diff[i] * $signed({1'b0, tin_s1[15:0]});
			ahi_s2[i] <= diff[i] * $signed({1'b0, tin_s1[hlc_pkg::TBITS-1:16]});
			blo_s2[i] <= diff[i] * $signed({1'b0, tout_s1[15:0]});
			bhi_s2[i] <= diff[i] * $signed({1'b0, tout_s1[hlc_pkg::TBITS-1:16]});
		end
	end

	logic vld_s3, vis_s3, mov_a_s3, mov_b_s3;
	hlc_pkg::seg_t seg_s3;
	logic signed [35:0] sha_s3 [4];
	logic signed [35:0] shb_s3 [4];
	logic signed [65:0] prod_a [4];
	logic signed [65:0] prod_b [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod_a[i] = 66'(alo_s2[i]) + (66'(ahi_s2[i]) <<< 16) + 66'sd536870912;
			prod_b[i] = 66'(blo_s2[i]) + (66'(bhi_s2[i]) <<< 16) + 66'sd536870912;
		end
	end

	always_ff @(posedge clk) begin
		seg_s3   <= seg_s2;
		vis_s3   <= vis_s2;
		mov_a_s3 <= mov_a_s2;
		mov_b_s3 <= mov_b_s2;
		for (int i = 0; i < 4; i++) begin
			sha_s3[i] <= prod_a[i][65:30];
			shb_s3[i] <= prod_b[i][65:30];
		end
	end

	logic signed [31:0] qa [4];
	logic signed [31:0] qb [4];
	logic [31:0] ra [4];
	logic [31:0] rb [4];

	always_comb begin
		qa[0] = seg_s3.a_x; qa[1] = seg_s3.a_y; qa[2] = seg_s3.a_z; qa[3] = seg_s3.a_w;
		qb[0] = seg_s3.b_x; qb[1] = seg_s3.b_y; qb[2] = seg_s3.b_z; qb[3] = seg_s3.b_w;
		for (int i = 0; i < 4; i++) begin
			ra[i] = mov_a_s3 ? hlc_pkg::sat32(37'(sha_s3[i]) + 37'(qa[i])) : qa[i];
			rb[i] = mov_b_s3 ? hlc_pkg::sat32(37'(shb_s3[i]) + 37'(qa[i])) : qb[i];
		end
	end

	always_ff @(posedge clk) begin
		result.visible <= vis_s3;
		result.out_a_x <= ra[0];
		result.out_a_y <= ra[1];
		result.out_a_z <= ra[2];
		result.out_a_w <= ra[3];
		result.out_b_x <= rb[0];
		result.out_b_y <= rb[1];
		result.out_b_z <= rb[2];
		result.out_b_w <= rb[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= dv;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done   <= vld_s3;
		end
	end

`ifndef ASSERT_OFF
	a_move_vis: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && (mov_a_s1 || mov_b_s1) |-> vis_s1) else $error("move on hidden word");
	a_tin_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> tin_s1 <= hlc_pkg::TONE) else $error("entry parameter out of range");
	a_done_seq: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |=> done) else $error("result strobe lost");
`endif

endmodule

// File: design/homogeneous_line_clipper_top.sv
// Top level of the homogeneous Liang-Barsky line clipper.
// Takes one segment per clock cycle while busy is low; the result word appears on
// result, with done high for one cycle, after the queue write and read, the
// 31-stage crossing divider and four interpolation stages. busy rises only if
// the queue fills; the back end drains it every cycle.
module homogeneous_line_clipper_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  hlc_pkg::seg_t  item,
	output logic           busy,
	output logic           done,
	output hlc_pkg::clip_t result
);

	hlc_pkg::ent_t fe;
	hlc_pkg::ent_t qe;
	logic          qv;
	logic          full;

	hlc_front u_front (
		.seg (item),
		.ent (fe)
	);

	hlc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (start && !full),
		.push_word  (fe),
		.full       (full),
		.rd_valid_q (qv),
		.rd_word_q  (qe)
	);

	hlc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (qv),
		.in_ent   (qe),
		.done     (done),
		.result   (result)
	);

	assign busy = full;

endmodule
